// ===== src/mfps_pkg.sv =====
// Shared constants and types for the minimum falling path sum block.
package mfps_pkg;

   localparam int MAX_SIZE_DEF   = 64;
   localparam int VALUE_BITS_DEF = 16;
   localparam int SIZE_W         = 7;
   localparam int SIZE_RESET     = 64;
   localparam int OUT_W          = 22;
   localparam int RSP_DATA_W     = ((OUT_W + 7) / 8) * 8;
   localparam int MIN_RESET_W    = 23;
   localparam int MIN_RESET      = (1 << (OUT_W)) - 1;

   // position flags carried from the accept stage to the update stage
   typedef struct packed {
      logic first_row;
      logic last_row;
      logic has_left;
      logic has_right;
      logic final_item;
   } mfps_flags_type;

endpackage

// ===== src/mfps_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module mfps_ram #(
   parameter int Width = 8,
   parameter int Depth = 16,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] waddr,
   input  logic [Width-1:0] wdata,
   input  logic [AddrW-1:0] raddr0,
   input  logic [AddrW-1:0] raddr1,
   output logic [Width-1:0] rdata0,
   output logic [Width-1:0] rdata1
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata0_ff;
   logic [Width-1:0] rdata1_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata0_ff <= mem[raddr0];
      rdata1_ff <= mem[raddr1];
   end

   assign rdata0 = rdata0_ff;
   assign rdata1 = rdata1_ff;

endmodule

// ===== src/min_falling_path_sum.sv =====
// The result is offered on rsp once the update stage has pushed the matrix's last sum.
// Throughput: one element per cycle; the sum memory is read the cycle an element is
// taken and written back the next, with forwarding across the read/write overlap.
// req stalls while queued results plus one about to enter, less any leaving, reach two.
// Reset: counts cleared, matrix size 64, running minimum at its top value; the sum
// memory is not cleared, since the first row of every matrix writes each entry.
module min_falling_path_sum #(
   parameter int MAX_SIZE   = mfps_pkg::MAX_SIZE_DEF,
   parameter int VALUE_BITS = mfps_pkg::VALUE_BITS_DEF,
   localparam int ReqDataW  = ((VALUE_BITS + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ReqDataW-1:0]             req_tdata,   // [VALUE_BITS-1:0] value
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mfps_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [21:0] min_sum
   input  logic                            csr_we,
   input  logic [mfps_pkg::SIZE_W-1:0]     csr_wdata    // matrix_size
);

   import mfps_pkg::*;

   localparam int CntW   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int NeedW  = VALUE_BITS + CntW + 1;
   localparam int SumW   = (NeedW > MIN_RESET_W) ? NeedW : MIN_RESET_W;
   localparam int SzW    = ((CntW > SIZE_W) ? CntW : SIZE_W) + 1;
   localparam int RstSz  = (MAX_SIZE < SIZE_RESET) ? MAX_SIZE : SIZE_RESET;

   // ---------------- accept stage ----------------
   logic [CntW-1:0]        last_ff, last_in;
   logic [CntW-1:0]        col_ff, col_in;
   logic [CntW-1:0]        row_ff, row_in;
   logic                   accept;
   logic [CntW-1:0]        rd_addr1;
   logic [SzW-1:0]         sz_ext;
   logic [SzW-1:0]         sz_eff;
   mfps_flags_type         a_flags;

   // ---------------- update stage ----------------
   logic                   b_valid_ff;
   logic [CntW-1:0]        b_col_ff;
   logic signed [VALUE_BITS-1:0] b_value_ff;
   mfps_flags_type         b_flags_ff;
   logic                   fwd_valid_ff;
   logic [CntW-1:0]        fwd_addr_ff;
   logic signed [SumW-1:0] fwd_data_ff;
   logic signed [SumW-1:0] held_ff, held_in;
   logic signed [SumW-1:0] min_ff, min_in;
   logic [SumW-1:0]        rdata0, rdata1;
   logic signed [SumW-1:0] old_j, old_j1, best, sum, min_cand;
   logic                   push;

   // ---------------- output queue ----------------
   logic [1:0]             cnt_ff, cnt_in;
   logic [OUT_W-1:0]       slot0_ff, slot0_in;
   logic [OUT_W-1:0]       slot1_ff, slot1_in;
   logic                   pop;
   logic                   pos;

   // a result leaving this cycle frees its slot for the element taken now
   assign req_tready = ({1'b0, cnt_ff} + {2'b00, b_valid_ff & b_flags_ff.final_item}
                        - {2'b00, pop}) < 3'd2;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      a_flags.first_row  = (row_ff == '0);
      a_flags.last_row   = (row_ff == last_ff);
      a_flags.has_left   = (col_ff != '0);
      a_flags.has_right  = (col_ff != last_ff);
      a_flags.final_item = (row_ff == last_ff) && (col_ff == last_ff);
      rd_addr1 = (col_ff == last_ff) ? col_ff : col_ff + 1'b1;
   end

   // size decode: zero means one, oversize saturates
   always_comb begin
      sz_ext = SzW'(csr_wdata);
      if (sz_ext == '0) begin
         sz_eff = SzW'(1);
      end else if (sz_ext > SzW'(MAX_SIZE)) begin
         sz_eff = SzW'(MAX_SIZE);
      end else begin
         sz_eff = sz_ext;
      end
   end

   always_comb begin
      last_in = last_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (csr_we) begin
         last_in = CntW'(sz_eff - SzW'(1));
         col_in  = '0;
         row_in  = '0;
      end else if (accept) begin
         if (col_ff == last_ff) begin
            col_in = '0;
            row_in = (row_ff == last_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   mfps_ram #(
      .Width (SumW),
      .Depth (MAX_SIZE)
   ) u_sums (
      .clock  (clock),
      .we     (b_valid_ff),
      .waddr  (b_col_ff),
      .wdata  (sum),
      .raddr0 (col_ff),
      .raddr1 (rd_addr1),
      .rdata0 (rdata0),
      .rdata1 (rdata1)
   );

   // the write of the previous element lands on the same edge as this read
   always_comb begin
      old_j  = (fwd_valid_ff && fwd_addr_ff == b_col_ff) ? fwd_data_ff : $signed(rdata0);
      old_j1 = (fwd_valid_ff && fwd_addr_ff == b_col_ff + 1'b1 && b_flags_ff.has_right)
               ? fwd_data_ff : $signed(rdata1);
      best = old_j;
      if (b_flags_ff.has_left && held_ff < best) begin
         best = held_ff;
      end
      if (b_flags_ff.has_right && old_j1 < best) begin
         best = old_j1;
      end
      if (b_flags_ff.first_row) begin
         sum = SumW'(b_value_ff);
      end else begin
         sum = SumW'(b_value_ff) + best;
      end
      min_cand = (sum < min_ff) ? sum : min_ff;
      held_in  = b_valid_ff ? old_j : held_ff;
      min_in   = min_ff;
      if (csr_we) begin
         held_in = '0;
         min_in  = SumW'(MIN_RESET);
      end else if (b_valid_ff && b_flags_ff.last_row) begin
         min_in = b_flags_ff.final_item ? SumW'(MIN_RESET) : min_cand;
      end
      push = b_valid_ff & b_flags_ff.final_item;
   end

   // two-deep result queue
   always_comb begin
      pop      = (cnt_ff != 2'd0) && rsp_tready;
      pos      = (cnt_ff - {1'b0, pop}) != 2'd0;
      cnt_in   = cnt_ff + {1'b0, push} - {1'b0, pop};
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (push) begin
         if (!pos) begin
            slot0_in = min_cand[OUT_W-1:0];
         end else begin
            slot1_in = min_cand[OUT_W-1:0];
         end
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = RSP_DATA_W'(slot0_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff    <= CntW'(RstSz - 1);
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
         held_ff    <= '0;
         min_ff     <= SumW'(MIN_RESET);
         cnt_ff     <= 2'd0;
      end else begin
         last_ff    <= last_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         b_valid_ff <= accept;
         held_ff    <= held_in;
         min_ff     <= min_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      b_col_ff     <= col_ff;
      b_value_ff   <= $signed(req_tdata[VALUE_BITS-1:0]);
      b_flags_ff   <= a_flags;
      fwd_valid_ff <= b_valid_ff;
      fwd_addr_ff  <= b_col_ff;
      fwd_data_ff  <= sum;
      slot0_ff     <= slot0_in;
      slot1_ff     <= slot1_in;
   end

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue overflow");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !rsp_tready) |-> !req_tready)
      else $error("input taken with full result queue");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= last_ff) && (row_ff <= last_ff))
      else $error("position beyond matrix size");

   a_final_wraps: assert property (@(posedge clock) disable iff (reset)
      (accept && a_flags.final_item) |=> (col_ff == '0 && row_ff == '0))
      else $error("counts not restarted after final element");

   a_final_pushes: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_flags_ff.final_item) |=> (cnt_ff != 2'd0))
      else $error("final element left no result");

endmodule

// ===== tb/min_falling_path_sum_tb.sv =====
// Self-checking testbench for the minimum falling path sum block: directed cases, random matrices.
module min_falling_path_sum_tb;
   import mfps_pkg::*;

   localparam int VALUE_W      = VALUE_BITS_DEF;
   localparam int SUM_W        = MIN_RESET_W;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 400_000;
   localparam int PHASE_ITEMS  = 130;

   typedef struct {
      bit                 set_size;
      logic [SIZE_W-1:0]  size;
      int                 count;
      logic [VALUE_W-1:0] value;
      bit                 typed;
      logic [OUT_W-1:0]   sum;
   } directed_case_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [VALUE_W-1:0]    req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we      = 1'b0;
   logic [SIZE_W-1:0]     csr_wdata   = '0;

   // predictor state
   logic signed [SUM_W-1:0] path_sums [MAX_SIZE_DEF];
   logic signed [SUM_W-1:0] held_left_sum = '0;
   logic signed [SUM_W-1:0] running_min   = SUM_W'(MIN_RESET);
   logic [SIZE_W-1:0]       size_reg      = SIZE_W'(SIZE_RESET);
   int                      col_idx       = 0;
   int                      row_idx       = 0;

   logic [OUT_W-1:0] pending_min_sums [$];
   int               errors      = 0;
   int               accepted    = 0;
   int               cycle_count = 0;
   int               snd_idle_pct = 32;
   int               rsp_idle_pct = 72;
   logic             hold_toggle = 1'b0;
   logic             hold_seen   = 1'b0;
   int               hold_left   = 0;

   directed_case_type directed_cases [14] = '{
      '{1'b0, 7'd0,   66,   16'h8000, 1'b0, 22'h0},      // size from reset, into row two
      '{1'b1, 7'd127, 66,   16'h7FFF, 1'b0, 22'h0},      // oversize clamps to 64
      '{1'b1, 7'd1,   1,    16'h7FFF, 1'b1, 22'h007FFF},
      '{1'b0, 7'd1,   1,    16'h8000, 1'b1, 22'h3F8000},
      '{1'b1, 7'd0,   1,    16'h0005, 1'b1, 22'h000005}, // size zero acts as one
      '{1'b1, 7'd3,   9,    16'h8000, 1'b1, 22'h3E8000},
      '{1'b1, 7'd4,   16,   16'h0000, 1'b1, 22'h000000},
      '{1'b1, 7'd8,   64,   16'h8000, 1'b1, 22'h3C0000}, // most negative
      '{1'b1, 7'd8,   64,   16'h7FFF, 1'b1, 22'h03FFF8}, // most positive
      '{1'b1, 7'd3,   4,    16'h0100, 1'b0, 22'h0},      // abandoned part-way
      '{1'b1, 7'd2,   1,    16'h0001, 1'b0, 22'h0},      // restart mid-matrix
      '{1'b0, 7'd2,   1,    16'hFFFF, 1'b0, 22'h0},
      '{1'b0, 7'd2,   1,    16'h0003, 1'b0, 22'h0},
      '{1'b0, 7'd2,   1,    16'hFFFB, 1'b0, 22'h0}
   };

   min_falling_path_sum DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int matrix_span();
      if (size_reg == 0) return 1;
      if (size_reg > MAX_SIZE_DEF) return MAX_SIZE_DEF;
      return int'(size_reg);
   endfunction

   function automatic void clear_walk();
      col_idx       = 0;
      row_idx       = 0;
      held_left_sum = '0;
      running_min   = SUM_W'(MIN_RESET);
   endfunction

   function automatic void set_matrix_size(input logic [SIZE_W-1:0] sz);
      size_reg = sz;
      clear_walk();
   endfunction

   // one element in; returns 1 with the path minimum once the matrix is complete
   function automatic bit advance_path_sums(input logic signed [VALUE_W-1:0] v,
                                            output logic [OUT_W-1:0] min_sum);
      int                      n;
      int                      j;
      logic signed [SUM_W-1:0] best;
      logic signed [SUM_W-1:0] s;
      n = matrix_span();
      j = col_idx;
      min_sum = '0;
      if (j >= n) j = n - 1;
      if (row_idx >= n) row_idx = n - 1;
      if (row_idx == 0) begin
         s = v;
      end else begin
         best = path_sums[j];
         if (j > 0 && held_left_sum < best) best = held_left_sum;
         if (j + 1 < n && path_sums[j+1] < best) best = path_sums[j+1];
         s = v + best;
      end
      held_left_sum = path_sums[j];
      path_sums[j] = s;
      if (row_idx == n - 1 && s < running_min) running_min = s;
      if (j + 1 < n) begin
         col_idx = j + 1;
         return 1'b0;
      end
      col_idx = 0;
      if (row_idx + 1 < n) begin
         row_idx++;
         return 1'b0;
      end
      min_sum = running_min[OUT_W-1:0];
      clear_walk();
      return 1'b1;
   endfunction

   function automatic logic [VALUE_W-1:0] random_element();
      case ($urandom_range(9))
         0, 1:    return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         2, 3:    return 16'($urandom_range(16)) - 16'd8; // near zero, so ties are common
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] random_size();
      int r;
      r = $urandom_range(99);
      if (r < 5) return '0;
      if (r < 50) return SIZE_W'($urandom_range(3, 1));
      if (r < 90) return SIZE_W'($urandom_range(6, 4));
      return SIZE_W'($urandom_range(10, 7));
   endfunction

   task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                  input logic [OUT_W-1:0] want);
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what,
               $signed(got), $signed(want));
      errors++;
   endtask

   task automatic push_element(input logic [VALUE_W-1:0] v, input bit typed,
                               input logic [OUT_W-1:0] typed_sum);
      logic [OUT_W-1:0] sum;
      bit               done;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= VALUE_W'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      done = advance_path_sums(v, sum);
      if (done) pending_min_sums.push_back(typed ? typed_sum : sum);
      accepted++;
   endtask

   // stop sending, let every result come back and the pipeline empty
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_min_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_matrix_size(input logic [SIZE_W-1:0] sz);
      settle_block();
      csr_we    <= 1'b1;
      csr_wdata <= sz;
      @(posedge clock);
      set_matrix_size(sz);
      csr_we    <= 1'b0;
   endtask

   task automatic run_random_phase(input int quota);
      int first;
      int total;
      int count;
      bit restart_due;
      first = accepted;
      restart_due = 1'b1;
      while (accepted - first < quota) begin
         if (restart_due || $urandom_range(99) < 35) begin
            write_matrix_size(random_size());
            restart_due = 1'b0;
         end
         total = matrix_span() * matrix_span();
         count = total;
         // now and then cut a matrix short and force a size write
         if (total > 1 && $urandom_range(99) < 12) begin
            count = $urandom_range(total - 1, 1);
            restart_due = 1'b1;
         end
         repeat (count) push_element(random_element(), 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : result_check
      logic [OUT_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_min_sums.size() == 0) begin
            report_mismatch("transaction with none pending", rsp_tdata[OUT_W-1:0], '0);
         end else begin
            want = pending_min_sums.pop_front();
            if (rsp_tdata[OUT_W-1:0] !== want)
               report_mismatch("min_sum", rsp_tdata[OUT_W-1:0], want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int i;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cases[c]) begin
         if (directed_cases[c].set_size) write_matrix_size(directed_cases[c].size);
         for (i = 0; i < directed_cases[c].count; i++)
            push_element(directed_cases[c].value,
                         directed_cases[c].typed && i == directed_cases[c].count - 1,
                         directed_cases[c].sum);
      end

      run_random_phase(PHASE_ITEMS);

      settle_block();
      snd_idle_pct = 72;
      rsp_idle_pct = 32;
      run_random_phase(PHASE_ITEMS);

      settle_block();
      snd_idle_pct = 0;
      rsp_idle_pct = 0;
      // single-element matrices under a long receiver hold-off back up the result queue
      write_matrix_size(7'd1);
      hold_toggle <= ~hold_toggle;
      repeat (40) push_element(random_element(), 1'b0, '0);
      settle_block();
      run_random_phase(PHASE_ITEMS);

      settle_block();
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/mfps_pkg.sv
src/mfps_ram.sv
src/min_falling_path_sum.sv
tb/min_falling_path_sum_tb.sv
